// File: hw/rtl/ilist_pkg.sv
// shared types and constants for the indexed list unit
package ilist_pkg;

	localparam int CAPACITY = 16;
	localparam int OP_W     = 3;
	localparam int INDEX_W  = 5;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 5;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

	typedef enum logic [OP_W-1:0] {
		OP_READ         = 3'd0,
		OP_INSERT_FRONT = 3'd1,
		OP_INSERT_BACK  = 3'd2,
		OP_INSERT_AT    = 3'd3,
		OP_DELETE_AT    = 3'd4
	} op_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic               ins;
		logic               del;
		logic [CMP_W-1:0]   pos;
		logic [VALUE_W-1:0] value;
	} cell_cmd_t;

endpackage

// File: hw/rtl/ilist_in_if.sv
// request channel: operation, index and value with valid/ready
interface ilist_in_if;
	logic                        valid;
	logic                        ready;
	logic [ilist_pkg::OP_W-1:0]  operation;
	logic [ilist_pkg::INDEX_W-1:0] index;
	logic signed [ilist_pkg::VALUE_W-1:0] value;

	modport source(output valid, output operation, output index, output value, input ready);
	modport sink(input valid, input operation, input index, input value, output ready);
endinterface

// File: hw/rtl/ilist_out_if.sv
// response channel: read value, ok flag and count with valid/ready
interface ilist_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ilist_pkg::VALUE_W-1:0] read_value;
	logic                                 ok;
	logic [ilist_pkg::COUNT_W-1:0]        count;

	modport source(output valid, output read_value, output ok, output count, input ready);
	modport sink(input valid, input read_value, input ok, input count, output ready);
endinterface

// File: hw/rtl/ilist_cell.sv
// one list position: holds an entry, shifts with its neighbors, taps the read chain
module ilist_cell (
	input  logic                        clk,
	input  ilist_pkg::cell_cmd_t        cmd,
	input  logic [ilist_pkg::CMP_W-1:0] idx,
	input  logic [ilist_pkg::VALUE_W-1:0] left,
	input  logic [ilist_pkg::VALUE_W-1:0] right,
	input  logic [ilist_pkg::VALUE_W-1:0] rd_in,
	output logic [ilist_pkg::VALUE_W-1:0] entry,
	output logic [ilist_pkg::VALUE_W-1:0] rd_out
);
	import ilist_pkg::*;

	logic [VALUE_W-1:0] entry_q;
	logic               hit;

	assign hit   = (idx == cmd.pos);
	assign entry = entry_q;

	// entry update: shift up past the insert point, shift down from the delete point
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (hit) begin
				entry_q <= cmd.value;
			end else if (idx > cmd.pos) begin
				entry_q <= left;
			end
		end else if (cmd.del) begin
			if (idx >= cmd.pos) begin
				entry_q <= right;
			end
		end
	end

	// read chain: only the addressed cell contributes
	assign rd_out = rd_in | (hit ? entry_q : '0);

endmodule

// File: hw/rtl/indexed_list_insert_delete_unit.sv
// top level of the indexed list unit: decode, count, cell chain and response register
//
// Keeps an ordered list of up to CAPACITY signed 32-bit entries and a count.
// Request channel req carries operation, index and value; response channel
// rsp carries read_value, ok and count, one response word per request word.
// Operations: read at index, insert front, insert back, insert at index and
// delete at index. Failed operations change nothing and return ok low; a
// failed read and every non-read operation return read_value of all ones.
// All entries sit in a row of cells that shift together, so a request is
// decoded, applied and its response registered in the cycle it is accepted,
// and one request word is taken per cycle while rsp is not stalled. When
// rsp stalls, req.ready drops until the waiting response word is taken; a
// new request is taken in the same cycle the old response leaves. Reset
// clears the count and the response valid; entries are not cleared and
// only positions below the count are read.
module indexed_list_insert_delete_unit (
	input  logic        clk,
	input  logic        arst_n,
	ilist_in_if.sink    req,
	ilist_out_if.source rsp
);
	import ilist_pkg::*;

	logic [CNT_W-1:0]   count_q;
	logic               rsp_valid_q;
	logic [VALUE_W-1:0] rsp_value_q;
	logic               rsp_ok_q;

	op_t                op;
	logic               fire;
	logic               full;
	logic [CMP_W-1:0]   cnt_ext;
	logic [CMP_W-1:0]   idx_ext;
	logic [CMP_W-1:0]   pos_eff;
	logic               is_ins;
	logic               is_del;
	logic               is_rd;
	logic               ins_ok;
	logic               del_ok;
	logic               rd_ok;
	logic               op_ok;
	cell_cmd_t          cmd;

	logic [VALUE_W-1:0] ent [CAPACITY];
	logic [VALUE_W-1:0] rd_chain [CAPACITY+1];

	assign op      = op_t'(req.operation);
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire    = req.valid && req.ready;
	assign full    = (count_q == CNT_W'(CAPACITY));
	assign cnt_ext = CMP_W'(count_q);
	assign idx_ext = CMP_W'(req.index);

	// operation decode and effective position
	always_comb begin
		is_ins  = 1'b0;
		is_del  = 1'b0;
		is_rd   = 1'b0;
		pos_eff = idx_ext;
		unique case (op)
			OP_READ: begin
				is_rd = 1'b1;
			end
			OP_INSERT_FRONT: begin
				is_ins  = 1'b1;
				pos_eff = '0;
			end
			OP_INSERT_BACK: begin
				is_ins  = 1'b1;
				pos_eff = cnt_ext;
			end
			OP_INSERT_AT: begin
				is_ins = 1'b1;
			end
			OP_DELETE_AT: begin
				is_del = 1'b1;
			end
			default: begin
				pos_eff = idx_ext;
			end
		endcase
	end

	// range and full checks
	assign ins_ok = is_ins && (pos_eff <= cnt_ext) && !full;
	assign del_ok = is_del && (idx_ext < cnt_ext);
	assign rd_ok  = is_rd && (idx_ext < cnt_ext);
	assign op_ok  = ins_ok || del_ok || rd_ok;

	// command broadcast to the cell chain
	always_comb begin
		cmd.ins   = fire && ins_ok;
		cmd.del   = fire && del_ok;
		cmd.pos   = pos_eff;
		cmd.value = req.value;
	end

	// chain of cells, each handing its entry to both neighbors
	assign rd_chain[0] = '0;
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ilist_cell u_cell (
			.clk    (clk),
			.cmd    (cmd),
			.idx    (CMP_W'(i)),
			.left   ((i == 0) ? req.value : ent[(i == 0) ? 0 : i-1]),
			.right  ((i == CAPACITY-1) ? ent[i] : ent[(i == CAPACITY-1) ? i : i+1]),
			.rd_in  (rd_chain[i]),
			.entry  (ent[i]),
			.rd_out (rd_chain[i+1])
		);
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.del) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_value_q <= rd_ok ? rd_chain[CAPACITY] : '1;
			rsp_ok_q    <= op_ok;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_value_q;
	assign rsp.ok         = rsp_ok_q;
	assign rsp.count      = COUNT_W'(count_q);

	// count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// a failed operation leaves the count alone
	a_fail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !op_ok) |=> $stable(count_q))
		else $error("count changed on a failed operation");

	// a successful insert grows the count by one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ins_ok) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the count");

	// a response without ok carries all ones
	a_fail_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ok_q) |-> (rsp_value_q == '1))
		else $error("failed response with a value");

endmodule
